// ===== hdl/lzwe_pkg.sv =====
// Shared types and constants for the 12-bit LZW encoder.
`default_nettype none

package lzwe_pkg;

  localparam int CODE_BITS      = 12;
  localparam int BYTE_W         = 8;
  localparam int TABLE_SIZE_DEF = 5021;
  // Up to seven leftover bits sit above a freshly loaded code.
  localparam int ACC_W          = CODE_BITS + 7;
  localparam int CNT_W          = 5;

  localparam logic [CODE_BITS-1:0] FIRST_CODE    = 12'd256;
  localparam logic [CODE_BITS-1:0] LAST_ASSIGNED = 12'd4094;
  localparam logic [CODE_BITS-1:0] END_MARK      = 12'd4095;
  localparam logic [CODE_BITS-1:0] ZERO_CODE     = 12'd0;

  typedef enum logic [1:0] {
    TAIL_CUR,
    TAIL_END,
    TAIL_ZERO
  } tail_e;

  typedef struct packed {
    logic                 valid;
    logic [CODE_BITS-1:0] code;
    logic [CODE_BITS-1:0] prefix;
    logic [BYTE_W-1:0]    append;
  } entry_t;

  typedef struct packed {
    logic  accept;
    logic  probe_step;
    logic  hit;
    logic  miss;
    logic  load_tail;
    tail_e tail;
    logic  push;
    logic  mark_run;
    logic  mark_stream;
    logic  end_stream;
    logic  sweep;
  } cmd_t;

  typedef struct packed {
    logic have_first;
    logic slot_empty;
    logic slot_hit;
    logic exhausted;
    logic code_done;
    logic out_free;
    logic clr_done;
  } sts_t;

endpackage

`default_nettype wire

// ===== hdl/lzw_encoder_12bit_core.sv =====
// Top level of the 12-bit LZW encoder.
// Compresses a byte stream with fixed 12-bit LZW codes packed MSB first; the last
// input byte adds the final code, 4095 and 0, and leftover bits below a byte are
// dropped. The first byte of a stream starts the string; each other byte is
// hashed and the table probed, one dictionary read per cycle, until a hit, an empty
// slot or a full search; a byte that ends a string sends the finished code out a byte
// at a time as the output allows, and on the last byte each closing code is loaded and
// sent. After reset and after every stream end the dictionary is swept clear, one
// entry a cycle, with input stalled.
`default_nettype none

module lzw_encoder_12bit_core #(
  parameter int TABLE_SIZE = lzwe_pkg::TABLE_SIZE_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [lzwe_pkg::BYTE_W-1:0] data_byte_i,
  input  wire logic                        last_byte_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [lzwe_pkg::BYTE_W-1:0]      out_byte_o,
  output logic                             run_end_o,
  output logic                             stream_end_o
);

  lzwe_pkg::cmd_t cmd;
  lzwe_pkg::sts_t sts;

  lzwe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .last_byte_i (last_byte_i),
    .in_stall_o  (in_stall_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  lzwe_dpath #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .data_byte_i  (data_byte_i),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .out_byte_o   (out_byte_o),
    .run_end_o    (run_end_o),
    .stream_end_o (stream_end_o)
  );

endmodule

`default_nettype wire

// ===== hdl/lzwe_ctrl.sv =====
// Controller state machine of the LZW encoder.
`default_nettype none

module lzwe_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          last_byte_i,
  output logic               in_stall_o,
  input  wire lzwe_pkg::sts_t sts_i,
  output lzwe_pkg::cmd_t     cmd_o
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_PROBE = 3'd2;
  localparam logic [2:0] ST_LOAD  = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  logic [2:0]          state_q, state_d;
  lzwe_pkg::tail_e     tail_q, tail_d;
  logic                final_q, final_d;
  logic                last_q, last_d;

  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    tail_d     = tail_q;
    final_d    = final_q;
    last_d     = last_q;
    in_stall_o = (state_q != ST_IDLE);
    case (state_q)
      ST_CLEAR: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.clr_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          last_d       = last_byte_i;
          if (sts_i.have_first) begin
            state_d = ST_PROBE;
          end else if (last_byte_i) begin
            tail_d  = lzwe_pkg::TAIL_CUR;
            state_d = ST_LOAD;
          end
        end
      end
      ST_PROBE: begin
        if (sts_i.slot_hit) begin
          cmd_o.hit = 1'b1;
          if (last_q) begin
            tail_d  = lzwe_pkg::TAIL_CUR;
            state_d = ST_LOAD;
          end else begin
            state_d = ST_IDLE;
          end
        end else if (sts_i.slot_empty || sts_i.exhausted) begin
          cmd_o.miss = 1'b1;
          final_d    = !last_q;
          tail_d     = lzwe_pkg::TAIL_CUR;
          state_d    = ST_EMIT;
        end else begin
          cmd_o.probe_step = 1'b1;
        end
      end
      ST_LOAD: begin
        cmd_o.load_tail = 1'b1;
        cmd_o.tail      = tail_q;
        final_d         = (tail_q == lzwe_pkg::TAIL_ZERO);
        case (tail_q)
          lzwe_pkg::TAIL_CUR: tail_d = lzwe_pkg::TAIL_END;
          default:            tail_d = lzwe_pkg::TAIL_ZERO;
        endcase
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.push        = 1'b1;
          cmd_o.mark_run    = final_q && sts_i.code_done;
          cmd_o.mark_stream = final_q && sts_i.code_done && last_q;
          if (sts_i.code_done) begin
            if (!final_q) begin
              state_d = ST_LOAD;
            end else if (last_q) begin
              cmd_o.end_stream = 1'b1;
              state_d          = ST_CLEAR;
            end else begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      tail_q  <= lzwe_pkg::TAIL_CUR;
      final_q <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      tail_q  <= tail_d;
      final_q <= final_d;
      last_q  <= last_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lzwe_dpath.sv =====
// Datapath of the LZW encoder: hash table, probe unit, bit packer, output register.
`default_nettype none

module lzwe_dpath #(
  parameter int TABLE_SIZE = lzwe_pkg::TABLE_SIZE_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire lzwe_pkg::cmd_t                cmd_i,
  output lzwe_pkg::sts_t                     sts_o,
  input  wire logic [lzwe_pkg::BYTE_W-1:0]   data_byte_i,
  input  wire logic                          out_stall_i,
  output logic                               out_valid_o,
  output logic [lzwe_pkg::BYTE_W-1:0]        out_byte_o,
  output logic                               run_end_o,
  output logic                               stream_end_o
);

  localparam int CB    = lzwe_pkg::CODE_BITS;
  localparam int BW    = lzwe_pkg::BYTE_W;
  localparam int AW    = lzwe_pkg::ACC_W;
  localparam int CW    = lzwe_pkg::CNT_W;
  localparam int IDX_W = $clog2(TABLE_SIZE);

  localparam logic [IDX_W:0]   TSIZE    = (IDX_W+1)'(TABLE_SIZE);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);
  localparam logic [CW-1:0]    CNT_BYTE = CW'(BW);
  localparam logic [CW-1:0]    CNT_CODE = CW'(CB);
  localparam logic [CW-1:0]    CNT_TWO  = CW'(2 * BW);

  lzwe_pkg::entry_t mem [TABLE_SIZE];
  lzwe_pkg::entry_t rdata_q;
  lzwe_pkg::entry_t wdata;

  logic [IDX_W-1:0] idx_q, idx_d, step_q, tries_q, clr_q, waddr;
  logic [IDX_W-1:0] hash_idx, hash_step, next_idx;
  logic [CB-1:0]    hash;
  logic [BW-1:0]    byte_q;
  logic [CB-1:0]    cur_q, next_free_q;
  logic             have_first_q;
  logic [AW-1:0]    acc_q, shifted;
  logic [CW-1:0]    cnt_q;
  logic             out_valid_q, run_end_q, stream_end_q;
  logic [BW-1:0]    out_byte_q;
  logic [CB-1:0]    tail_code;
  logic             ins_ok, we;

  // The XOR stays below 4096, which is under the default table size of 5021, so no modulo.
  assign hash      = cur_q ^ {data_byte_i, 4'b0000};
  assign hash_idx  = {{(IDX_W-CB){1'b0}}, hash};
  assign hash_step = (hash_idx == '0) ? IDX_W'(1) : IDX_W'(TSIZE - {1'b0, hash_idx});
  assign next_idx  = (idx_q >= step_q) ? (idx_q - step_q)
                                       : IDX_W'({1'b0, idx_q} + TSIZE - {1'b0, step_q});

  always_comb begin
    if (cmd_i.accept)          idx_d = hash_idx;
    else if (cmd_i.probe_step) idx_d = next_idx;
    else                       idx_d = idx_q;
  end

  assign sts_o.have_first = have_first_q;
  assign sts_o.slot_empty = !rdata_q.valid;
  assign sts_o.slot_hit   = rdata_q.valid && (rdata_q.prefix == cur_q) &&
                            (rdata_q.append == byte_q);
  assign sts_o.exhausted  = rdata_q.valid && !sts_o.slot_hit && (tries_q == LAST_IDX);
  assign sts_o.code_done  = (cnt_q < CNT_TWO);
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;
  assign sts_o.clr_done   = (clr_q == LAST_IDX);

  assign ins_ok = !rdata_q.valid && (next_free_q <= lzwe_pkg::LAST_ASSIGNED);
  assign we     = cmd_i.sweep || (cmd_i.miss && ins_ok);
  assign waddr  = cmd_i.sweep ? clr_q : idx_q;

  always_comb begin
    if (cmd_i.sweep) begin
      wdata = '0;
    end else begin
      wdata.valid  = 1'b1;
      wdata.code   = next_free_q;
      wdata.prefix = cur_q;
      wdata.append = byte_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[idx_d];
  end

  always_comb begin
    case (cmd_i.tail)
      lzwe_pkg::TAIL_CUR: tail_code = cur_q;
      lzwe_pkg::TAIL_END: tail_code = lzwe_pkg::END_MARK;
      default:            tail_code = lzwe_pkg::ZERO_CODE;
    endcase
  end

  // Top byte of the bits still held in the packer.
  assign shifted = acc_q >> (cnt_q - CNT_BYTE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_first_q <= 1'b0;
      cur_q        <= '0;
      next_free_q  <= lzwe_pkg::FIRST_CODE;
      cnt_q        <= '0;
      tries_q      <= '0;
      clr_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.accept && !have_first_q) begin
        cur_q        <= {{(CB-BW){1'b0}}, data_byte_i};
        have_first_q <= 1'b1;
      end
      if (cmd_i.hit)  cur_q <= rdata_q.code;
      if (cmd_i.miss) cur_q <= {{(CB-BW){1'b0}}, byte_q};
      if (cmd_i.miss && ins_ok) next_free_q <= next_free_q + CB'(1);

      if (cmd_i.accept)          tries_q <= '0;
      else if (cmd_i.probe_step) tries_q <= tries_q + IDX_W'(1);

      if (cmd_i.sweep) clr_q <= sts_o.clr_done ? '0 : clr_q + IDX_W'(1);

      if (cmd_i.miss || cmd_i.load_tail) cnt_q <= cnt_q + CNT_CODE;
      else if (cmd_i.push)               cnt_q <= cnt_q - CNT_BYTE;

      if (cmd_i.push)          out_valid_q <= 1'b1;
      else if (!out_stall_i)   out_valid_q <= 1'b0;

      if (cmd_i.end_stream) begin
        have_first_q <= 1'b0;
        cur_q        <= '0;
        next_free_q  <= lzwe_pkg::FIRST_CODE;
        cnt_q        <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      byte_q <= data_byte_i;
      idx_q  <= idx_d;
      step_q <= hash_step;
    end else begin
      idx_q <= idx_d;
    end
    // Bits above the pending count are never read out, so no masking.
    if (cmd_i.miss)           acc_q <= {acc_q[6:0], cur_q};
    else if (cmd_i.load_tail) acc_q <= {acc_q[6:0], tail_code};
    if (cmd_i.push) begin
      out_byte_q   <= shifted[BW-1:0];
      run_end_q    <= cmd_i.mark_run;
      stream_end_q <= cmd_i.mark_stream;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign run_end_o    = run_end_q;
  assign stream_end_o = stream_end_q;

endmodule

`default_nettype wire

// ===== hdl/lzwe_checker.sv =====
// Port-level checks for the LZW encoder, bound to the top level.
`default_nettype none

module lzwe_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_stall_o,
  input wire logic [lzwe_pkg::BYTE_W-1:0] data_byte_i,
  input wire logic                        last_byte_i,
  input wire logic                        out_valid_o,
  input wire logic                        out_stall_i,
  input wire logic [lzwe_pkg::BYTE_W-1:0] out_byte_o,
  input wire logic                        run_end_o,
  input wire logic                        stream_end_o
);

  // The end of the compressed stream always closes the request's run.
  a_stream_closes_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && stream_end_o |-> run_end_o)
    else $error("stream_end without run_end");

  // Dictionary sweep follows reset, so no input is taken straight away.
  a_sweep_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> in_stall_o)
    else $error("input taken before dictionary sweep");

  a_in_req_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=>
      in_valid_i && $stable(data_byte_i) && $stable(last_byte_i))
    else $error("input request changed while stalled");

  a_out_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output request dropped while stalled");

  a_out_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(out_byte_o) && $stable(run_end_o) && $stable(stream_end_o))
    else $error("output payload changed while stalled");

endmodule

bind lzw_encoder_12bit_core lzwe_checker u_lzwe_checker (.*);

`default_nettype wire
